FILE: hw/rtl/nsfc_pkg.sv
// Package: sentence type codes, header text, select masks and hex decode for the NMEA checker.
package nsfc_pkg;

  localparam int unsigned HDR_LEN   = 5;
  localparam int unsigned NUM_TYPES = 4;

  // Sentence type codes as reported on the result channel
  typedef enum logic [2:0] {
    STYPE_OTHER = 3'd0,
    STYPE_GGA   = 3'd1,
    STYPE_RMC   = 3'd2,
    STYPE_GSA   = 3'd3,
    STYPE_GSV   = 3'd4
  } stype_t;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Header text after '$', one row per type in priority order GGA, RMC, GSA, GSV
  typedef logic [7:0] hdr_row_t [HDR_LEN];
  localparam hdr_row_t HDR_TEXT [NUM_TYPES] = '{
    '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h56}
  };

  // Bit n set: select code n enables that type
  localparam logic [15:0] SELECT_MASK [NUM_TYPES] = '{
    16'h022A, 16'h044C, 16'h1070, 16'h1700
  };

  // Upper-case hex digit to nibble; anything else decodes to zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/nmea_sentence_filter_checker_unit.sv
// Top level: NMEA 0183 sentence checksum checker and type filter.
//
//  channel | ports                                   | direction | moves
//  --------+-----------------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_rx_byte          | in        | one received character
//  out     | out_valid, out_stall, out_sentence_type,| out       | one verdict per closed sentence
//          | out_computed_sum, out_received_sum,     |           |
//          | out_sum_matches, out_accepted           |           |
//  config  | psel, penable, pwrite, paddr, pwdata,   | in/out    | sentence_select at address 0
//          | prdata, pready                          |           |
//
// One character per cycle sustained. Each request lands in an input register;
// from there the sentence state updates and, at a newline inside a sentence,
// the verdict loads the output register from the sentence state.
// in_stall rises only when a newline sits in the input register while the
// output register still holds an untaken verdict; other characters pass.
// Reset (rst_n low, synchronous) clears the pipeline valids, the sentence
// state and sentence_select; no sentence is open after reset.
module nmea_sentence_filter_checker_unit
  import nsfc_pkg::*;
#(
  parameter int unsigned MAX_LEN = 128   // longest accepted sentence, '$' included (16..255)
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sentence_type,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic        out_sum_matches,
  output logic        out_accepted,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration: single register, any address in the word decodes to it
  // ---------------------------------------------------------------------------
  logic [3:0] select_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {28'd0, select_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_r <= 4'd0;
    end else if (cfg_wr && (paddr[1:0] == 2'd0 || paddr[1:0] != 2'd0)) begin
      select_r <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] byte_r;
  logic       s1_adv;      // input register consumed this cycle
  logic       in_take;

  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Sentence state
  // ---------------------------------------------------------------------------
  logic       in_sent_r,    in_sent_nxt;
  logic       prev_dol_r,   prev_dol_nxt;
  logic [7:0] count_r,      count_nxt;
  logic [3:0] hits_r,       hits_nxt;
  logic [7:0] xor_r,        xor_nxt;
  logic       star_r,       star_nxt;
  logic [1:0] digits_r,     digits_nxt;
  logic [7:0] rx_sum_r,     rx_sum_nxt;
  logic       too_long_r,   too_long_nxt;

  logic       is_dollar, is_lf, is_cr, is_star;
  logic       emit;        // byte in input register closes a sentence
  logic       out_free;

  assign is_dollar = (byte_r == CH_DOLLAR);
  assign is_lf     = (byte_r == CH_LF);
  assign is_cr     = (byte_r == CH_CR);
  assign is_star   = (byte_r == CH_STAR);
  assign emit      = s1_valid_r && !is_dollar && in_sent_r && is_lf;
  assign out_free  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid_r && (!emit || out_free);

  always_comb begin
    in_sent_nxt  = in_sent_r;
    prev_dol_nxt = prev_dol_r;
    count_nxt    = count_r;
    hits_nxt     = hits_r;
    xor_nxt      = xor_r;
    star_nxt     = star_r;
    digits_nxt   = digits_r;
    rx_sum_nxt   = rx_sum_r;
    too_long_nxt = too_long_r;

    if (s1_adv) begin
      if (is_dollar) begin
        // "$$" keeps the sentence opened by the first dollar
        if (!prev_dol_r) begin
          in_sent_nxt  = 1'b1;
          count_nxt    = 8'd0;
          hits_nxt     = 4'hF;
          xor_nxt      = 8'd0;
          star_nxt     = 1'b0;
          digits_nxt   = 2'd0;
          rx_sum_nxt   = 8'd0;
          too_long_nxt = 1'b0;
        end
        prev_dol_nxt = 1'b1;
      end else begin
        prev_dol_nxt = 1'b0;
        if (in_sent_r) begin
          if (is_lf) begin
            in_sent_nxt = 1'b0;
          end else if (!(is_cr && star_r)) begin
            // header compare over the first five characters
            if (count_r < 8'(HDR_LEN)) begin
              for (int k = 0; k < NUM_TYPES; k++) begin
                if (HDR_TEXT[k][count_r[2:0]] != byte_r) begin
                  hits_nxt[k] = 1'b0;
                end
              end
            end
            if (count_r != 8'hFF) begin
              count_nxt = count_r + 8'd1;
            end
            if (count_nxt >= 8'(MAX_LEN)) begin
              too_long_nxt = 1'b1;
            end
            if (!star_r) begin
              if (is_star) begin
                star_nxt = 1'b1;
              end else begin
                xor_nxt = xor_r ^ byte_r;
              end
            end else if (digits_r != 2'd2) begin
              rx_sum_nxt = {rx_sum_r[3:0], hex_value(byte_r)};
              digits_nxt = digits_r + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r  <= 1'b0;
      prev_dol_r <= 1'b0;
      count_r    <= 8'd0;
      hits_r     <= 4'hF;
      xor_r      <= 8'd0;
      star_r     <= 1'b0;
      digits_r   <= 2'd0;
      rx_sum_r   <= 8'd0;
      too_long_r <= 1'b0;
    end else begin
      in_sent_r  <= in_sent_nxt;
      prev_dol_r <= prev_dol_nxt;
      count_r    <= count_nxt;
      hits_r     <= hits_nxt;
      xor_r      <= xor_nxt;
      star_r     <= star_nxt;
      digits_r   <= digits_nxt;
      rx_sum_r   <= rx_sum_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict: first surviving header wins; short header means type other
  // ---------------------------------------------------------------------------
  stype_t     vtype;
  logic       vsel;
  logic       vmatch;

  always_comb begin
    vtype = STYPE_OTHER;
    vsel  = 1'b0;
    if (count_r >= 8'(HDR_LEN)) begin
      for (int k = NUM_TYPES - 1; k >= 0; k--) begin
        if (hits_r[k]) begin
          vtype = stype_t'(3'(k + 1));
          vsel  = SELECT_MASK[k][select_r];
        end
      end
    end
  end

  assign vmatch = (xor_r == rx_sum_r);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic       out_valid_r;
  stype_t     otype_r;
  logic [7:0] ocomp_r;
  logic [7:0] orecv_r;
  logic       omatch_r;
  logic       oacc_r;
  logic       out_load;

  assign out_load = emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      otype_r  <= vtype;
      ocomp_r  <= xor_r;
      orecv_r  <= rx_sum_r;
      omatch_r <= vmatch;
      oacc_r   <= vsel && vmatch && !too_long_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sentence_type = otype_r;
  assign out_computed_sum  = ocomp_r;
  assign out_received_sum  = orecv_r;
  assign out_sum_matches   = omatch_r;
  assign out_accepted      = oacc_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // a verdict is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !out_load)
    else $error("verdict overwritten while stalled");

  // accepted implies both the checksum and type checks passed
  a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && oacc_r |-> omatch_r && otype_r != STYPE_OTHER)
    else $error("accepted without match or known type");

  // match flag agrees with the sums it reports
  a_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> omatch_r == (ocomp_r == orecv_r))
    else $error("match flag inconsistent with sums");

  // input side only stalls behind a closing newline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> emit && out_valid_r && out_stall)
    else $error("input stalled without pending verdict");
`endif

endmodule

FILE: dv/nmea_sentence_filter_checker_unit_tb.sv
// Testbench for the NMEA sentence checker: byte driver, verdict monitor, inline verdict predictor.
`timescale 1ns / 1ps

module nmea_sentence_filter_checker_unit_tb
  import nsfc_pkg::*;
;

  localparam int unsigned SENT_MAX    = 128;
  localparam int unsigned DRAIN_WAIT  = 8;      // pipeline is two deep; a few spare cycles
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_CHARS = 120;

  localparam logic [1:0] SEL_ADDR = 2'd0;       // sentence_select register

  // Header text after '$', in type order GGA, RMC, GSA, GSV
  localparam logic [39:0] HDR_WORDS [4] = '{"GPGGA", "GPRMC", "GPGSA", "GPGSV"};
  // Bit n set: select code n enables that type
  localparam logic [15:0] SEL_MASKS [4] = '{16'h022A, 16'h044C, 16'h1070, 16'h1700};

  typedef struct packed {
    stype_t     kind;
    logic [7:0] calc_sum;
    logic [7:0] rx_sum;
    logic       sum_ok;
    logic       pass;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_sentence_type;
  logic [7:0]  out_computed_sum;
  logic [7:0]  out_received_sum;
  logic        out_sum_matches;
  logic        out_accepted;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  nmea_sentence_filter_checker_unit #(.MAX_LEN(SENT_MAX)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sentence_type (out_sentence_type),
    .out_computed_sum  (out_computed_sum),
    .out_received_sum  (out_received_sum),
    .out_sum_matches   (out_sum_matches),
    .out_accepted      (out_accepted),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  logic [7:0] char_feed [$];      // characters waiting for the driver
  verdict_t   verdicts_due [$];   // verdicts predicted, not yet seen on out
  int         fed_count = 0;
  int         chars_taken = 0;
  int         verdicts_seen = 0;
  int         accepted_seen = 0;
  int         errs = 0;
  int         cycle_count = 0;
  logic       steady = 1'b0;      // when set, neither side idles
  logic [7:0] build_sum = 8'h00;  // running XOR while composing a sentence

  logic [3:0] phase_codes [8] = '{4'd0, 4'd15, 4'd12, 4'd5, 4'd10, 4'd6, 4'd9, 4'd0};

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the sentence tracker, updated per accepted request
  // ---------------------------------------------------------------------------
  logic [3:0] select_code = 4'd0;
  logic       open_s = 1'b0;
  logic       after_dollar = 1'b0;
  logic [7:0] char_cnt = 8'd0;
  logic [3:0] hdr_hits = 4'hF;
  logic [7:0] xor_sum = 8'd0;
  logic       star_s = 1'b0;
  logic [1:0] digits_in = 2'd0;
  logic [7:0] rx_val = 8'd0;
  logic       long_s = 1'b0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end
    return v;
  endfunction

  task automatic track_char(input logic [7:0] c);
    verdict_t v;
    logic     chosen;
    int       k;
    // '$' opens a sentence unless it directly follows another '$'
    if (c == CH_DOLLAR) begin
      if (!after_dollar) begin
        open_s    = 1'b1;
        char_cnt  = 8'd0;
        hdr_hits  = 4'hF;
        xor_sum   = 8'd0;
        star_s    = 1'b0;
        digits_in = 2'd0;
        rx_val    = 8'd0;
        long_s    = 1'b0;
      end
      after_dollar = 1'b1;
      return;
    end
    after_dollar = 1'b0;
    if (!open_s) return;

    if (c == CH_LF) begin
      v.kind  = STYPE_OTHER;
      chosen  = 1'b0;
      // lowest surviving header wins; short headers give no type
      if (char_cnt >= 8'd5) begin
        for (k = 3; k >= 0; k--) begin
          if (hdr_hits[k]) begin
            v.kind = stype_t'(k + 1);
            chosen = SEL_MASKS[k][select_code];
          end
        end
      end
      v.calc_sum = xor_sum;
      v.rx_sum   = rx_val;
      v.sum_ok   = (xor_sum == rx_val);
      v.pass     = chosen && v.sum_ok && !long_s;
      verdicts_due.push_back(v);
      open_s = 1'b0;
      return;
    end

    // CR after the star is dropped entirely
    if (c == CH_CR && star_s) return;

    if (char_cnt < 8'd5) begin
      for (k = 0; k < 4; k++) begin
        if (HDR_WORDS[k][8*(4-char_cnt) +: 8] != c) hdr_hits[k] = 1'b0;
      end
    end
    if (char_cnt != 8'hFF) char_cnt = char_cnt + 8'd1;
    if (char_cnt >= SENT_MAX) long_s = 1'b1;

    if (!star_s) begin
      if (c == CH_STAR) star_s = 1'b1;
      else xor_sum = xor_sum ^ c;
    end else if (digits_in < 2'd2) begin
      rx_val    = {rx_val[3:0], nibble_of(c)};
      digits_in = digits_in + 2'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one request per accepted character, random idle cycles
  // ---------------------------------------------------------------------------
  function automatic logic take_break();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_char(in_rx_byte);
        chars_taken++;
      end
      // a stalled request holds its byte; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (char_feed.size() != 0 && !take_break()) begin
          in_valid   <= 1'b1;
          in_rx_byte <= char_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each verdict with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("verdict with no sentence pending: type %0d sum %0d",
                 out_sentence_type, out_computed_sum);
          errs++;
        end else begin
          want = verdicts_due.pop_front();
          field_check("sentence_type", 8'(want.kind), 8'(out_sentence_type));
          field_check("computed_sum", want.calc_sum, out_computed_sum);
          field_check("received_sum", want.rx_sum, out_received_sum);
          field_check("sum_matches", 8'(want.sum_ok), 8'(out_sum_matches));
          field_check("accepted", 8'(want.pass), 8'(out_accepted));
          if (want.pass) accepted_seen++;
        end
      end
      out_stall <= take_break();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c);
    char_feed.push_back(c);
    fed_count++;
  endtask

  // character that counts toward the checksum
  task automatic add_char(input logic [7:0] c);
    push_char(c);
    build_sum = build_sum ^ c;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 4'd10);
  endfunction

  task automatic push_digits(input logic [7:0] v);
    push_char(hex_char(v[7:4]));
    push_char(hex_char(v[3:0]));
  endtask

  // star, correct checksum, CR LF
  task automatic close_sum();
    push_char(CH_STAR);
    push_digits(build_sum);
    push_char(CH_CR);
    push_char(CH_LF);
  endtask

  task automatic push_sum(input string body);
    push_char(CH_DOLLAR);
    build_sum = 8'h00;
    add_text(body);
    close_sum();
  endtask

  // well-formed sentence of header k padded with commas; length is 9 + fill
  task automatic push_long(input int k, input int fill);
    int i;
    push_char(CH_DOLLAR);
    build_sum = 8'h00;
    for (i = 0; i < 5; i++) add_char(HDR_WORDS[k][8*(4-i) +: 8]);
    repeat (fill) add_char(",");
    close_sum();
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = CH_STAR;
    while (c == CH_STAR || c == CH_DOLLAR || c == CH_LF) begin
      if ($urandom_range(9) == 0) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(32, 126));
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_noise();
    string pool;
    pool = "0123456789ABCDEFabcfGZ:@/,";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // Mostly well-formed sentences with random content; the rest broken in
  // assorted ways (cut short, no star, bad or odd digits, trailing bytes).
  task automatic queue_random_sentence();
    int         shape, n, pick, i;
    logic [7:0] v;
    // stray bytes between sentences, any value
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(255)));
    end
    n = ($urandom_range(39) == 0) ? $urandom_range(110, 280) : $urandom_range(0, 24);
    push_char(CH_DOLLAR);
    build_sum = 8'h00;
    if ($urandom_range(15) == 0) push_char(CH_DOLLAR);
    pick = $urandom_range(5);
    if (pick < 4) begin
      for (i = 0; i < 5; i++) add_char(HDR_WORDS[pick][8*(4-i) +: 8]);
    end else if (pick == 4) begin
      add_text("GP");
      repeat (3) add_char(8'($urandom_range(65, 90)));
    end
    for (i = 0; i < n; i++) add_char(body_char());

    shape = $urandom_range(99);
    if (shape < 5) return;               // cut short: the next '$' restarts
    if (shape >= 12) begin
      push_char(CH_STAR);
      v = build_sum;
      if (shape < 22) begin
        push_digits(v ^ 8'($urandom_range(1, 255)));
      end else if (shape < 28) begin
        push_char(digit_noise());
        push_char(digit_noise());
      end else if (shape < 34) begin
        push_char(hex_char(v[3:0]));     // single digit
      end else begin
        push_digits(v);
        if (shape < 40) repeat ($urandom_range(1, 5)) push_char(body_char());
      end
    end
    if ($urandom_range(4) != 0) push_char(CH_CR);
    push_char(CH_LF);
  endtask

  // Register write, then read back; only called with the block idle
  task automatic write_select(input logic [3:0] code);
    logic [31:0] word;
    word = ($urandom() & 32'hFFFF_FFF0) | 32'(code);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SEL_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    select_code = code;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] !== code) begin
      $error("sentence_select readback: expected %0d, actual %0d", code, prdata[3:0]);
      errs++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // All characters taken, every verdict in, pipeline flushed
  task automatic wait_idle();
    while (char_feed.size() != 0 || in_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int stop_at;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: GGA and RMC selected
    write_select(4'd3);
    push_char(CH_LF);                        // newline outside a sentence
    push_sum("GPGGA,1");
    push_sum("GPRMC");
    push_sum("GPGSA");
    push_sum("GPGSV");
    push_text("$GP");                        // short header, no star
    push_char(CH_LF);
    push_text("$*");                         // star without digits
    push_char(CH_LF);
    push_text("$GPRMC,9");                   // lone dollar discards this
    push_sum("GPGGA");
    push_char(CH_DOLLAR);                    // doubled dollar keeps one sentence
    push_sum("GPGSV");
    push_text("$GPGSA*G5");                  // non-hex first digit
    push_char(CH_LF);
    push_text("$GPGSV*a1");                  // lower case is not hex
    push_char(CH_LF);
    push_text("$A*7");                       // one digit only
    push_char(CH_LF);
    push_text("$A*41XY");                    // bytes after the digits
    push_char(CH_CR);
    push_char(CH_LF);
    push_char(CH_DOLLAR);                    // CR before the star is data
    build_sum = 8'h00;
    add_text("GP");
    add_char(CH_CR);
    add_text("GGA");
    close_sum();
    push_char(CH_DOLLAR);                    // extreme byte values
    build_sum = 8'h00;
    add_char(8'hFF);
    add_char(8'h00);
    add_char(8'h80);
    add_char(8'h7F);
    close_sum();
    push_long(0, 119);                       // exactly MAX_LEN
    push_long(1, 120);                       // one past MAX_LEN
    push_long(3, 260);                       // count saturates
    wait_idle();

    // Random phases over a spread of select codes
    phase_codes[7] = 4'($urandom_range(15));
    for (ph = 0; ph < 8; ph++) begin
      write_select(phase_codes[ph]);
      steady = (ph == 3);
      stop_at = fed_count + PHASE_CHARS;
      while (fed_count < stop_at) queue_random_sentence();
      wait_idle();
    end
    steady = 1'b0;

    $display("Fed %0d characters under 9 select codes, broken and overlong sentences included.",
             chars_taken);
    $display("Checked %0d verdicts, %0d of them accepted.", verdicts_seen, accepted_seen);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/nsfc_pkg.sv
hw/rtl/nmea_sentence_filter_checker_unit.sv
dv/nmea_sentence_filter_checker_unit_tb.sv
